[sv/pbnc_pkg.sv]
// Shared types, constants and helper functions for the palette blend and nearest-colour block.
`timescale 1ns / 1ps

package pbnc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int CHAN_W  = 8;
    localparam int DIST_W  = 18;
    localparam int PCT_W   = 7;
    localparam int MUL_XW  = 15;
    localparam int MUL_YW  = 13;
    localparam int PROD_W  = MUL_XW + MUL_YW;

    localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

    // Division by one hundred is a multiplication by 5243 / 2**19, exact for sums up to 25500.
    localparam logic [MUL_YW-1:0] RECIP_100   = 13'd5243;
    localparam int                RECIP_SHIFT = 19;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_BLEND_PERCENT = 2'd0;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_BLEND  = 2'd1,
        REQ_RAW    = 2'd2,
        REQ_UNUSED = 2'd3
    } req_kind_t;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    function automatic logic [CHAN_W-1:0] rgb_pick(rgb_t c, logic [1:0] ch);
        logic [CHAN_W-1:0] v;
        unique case (ch)
            CH_RED:   v = c.r;
            CH_GREEN: v = c.g;
            default:  v = c.b;
        endcase
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[sv/pbnc_dist.sv]
// Pipelined squared RGB distance unit shared by every palette entry of a search.
`timescale 1ns / 1ps

module pbnc_dist
    import pbnc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               entry_valid,
    input  logic [$clog2(PALETTE_ENTRIES)-1:0] entry_idx,
    input  rgb_t                               entry,
    input  rgb_t                               target,
    output logic                               dist_valid,
    output logic [$clog2(PALETTE_ENTRIES)-1:0] dist_idx,
    output logic [DIST_W-1:0]                  dist_sum
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int SQ_W  = 2 * CHAN_W;

    logic             diff_v_reg;
    logic             diff_v_next;
    logic [IDX_W-1:0] diff_idx_reg;
    logic [IDX_W-1:0] diff_idx_next;
    rgb_t             diff_reg;
    rgb_t             diff_next;

    logic             sq_v_reg;
    logic             sq_v_next;
    logic [IDX_W-1:0] sq_idx_reg;
    logic [IDX_W-1:0] sq_idx_next;
    logic [SQ_W-1:0]  sq_r_reg;
    logic [SQ_W-1:0]  sq_r_next;
    logic [SQ_W-1:0]  sq_g_reg;
    logic [SQ_W-1:0]  sq_g_next;
    logic [SQ_W-1:0]  sq_b_reg;
    logic [SQ_W-1:0]  sq_b_next;

    always_comb
    begin
        diff_v_next   = entry_valid;
        diff_idx_next = entry_idx;
        diff_next.r   = abs_diff(target.r, entry.r);
        diff_next.g   = abs_diff(target.g, entry.g);
        diff_next.b   = abs_diff(target.b, entry.b);

        sq_v_next   = diff_v_reg;
        sq_idx_next = diff_idx_reg;
        sq_r_next   = SQ_W'(diff_reg.r) * SQ_W'(diff_reg.r);
        sq_g_next   = SQ_W'(diff_reg.g) * SQ_W'(diff_reg.g);
        sq_b_next   = SQ_W'(diff_reg.b) * SQ_W'(diff_reg.b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_v_reg <= 1'b0;
            sq_v_reg   <= 1'b0;
        end
        else
        begin
            diff_v_reg <= diff_v_next;
            sq_v_reg   <= sq_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_idx_reg <= diff_idx_next;
        diff_reg     <= diff_next;
        sq_idx_reg   <= sq_idx_next;
        sq_r_reg     <= sq_r_next;
        sq_g_reg     <= sq_g_next;
        sq_b_reg     <= sq_b_next;
    end

    assign dist_valid = sq_v_reg;
    assign dist_idx   = sq_idx_reg;
    assign dist_sum   = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

endmodule

[sv/palette_blend_nearest_color.sv]
// Top level of the palette blend and nearest-colour search block.
//
//  Channel   Direction  Handshake            Contents
//  request   in         req_valid/req_stall  req_type, entry_index, red, green, blue,
//                                            first_index, second_index
//  result    out        res_valid/res_stall  nearest_index, best_distance, exact_match
//  config    in         APB (psel..pready)   blend_percent at byte address 0
//
//  A write transfer leaves the sequencer idle, so requests can follow it back to back. A
//  query scans every palette entry through the single read port of the palette memory,
//  feeding one distance check per cycle; a blend query first mixes its two entries.
//  Reset clears the sequencer and blend_percent; the palette holds no defined value
//  until written. A stalled result holds in the output register while the next
//  request is accepted; a search only completes once the output register is free.
`timescale 1ns / 1ps

module palette_blend_nearest_color
    import pbnc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            req_type,
    input  logic [7:0]            entry_index,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            first_index,
    input  logic [7:0]            second_index,

    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [7:0]            nearest_index,
    output logic [DIST_W-1:0]     best_distance,
    output logic                  exact_match
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [8:0]       ENTRIES_9 = 9'(PALETTE_ENTRIES);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_RD_A   = 12'b0000_0000_0010,
        S_RD_B   = 12'b0000_0000_0100,
        S_CAP_B  = 12'b0000_0000_1000,
        S_MUL_A  = 12'b0000_0001_0000,
        S_MUL_B  = 12'b0000_0010_0000,
        S_ADD    = 12'b0000_0100_0000,
        S_DIV    = 12'b0000_1000_0000,
        S_TGT    = 12'b0001_0000_0000,
        S_SCAN   = 12'b0010_0000_0000,
        S_DRAIN  = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [PCT_W-1:0]    blend_reg;
    logic [PCT_W-1:0]    blend_next;
    logic [1:0]          ch_reg;
    logic [1:0]          ch_next;
    logic [IDX_W-1:0]    scan_reg;
    logic [IDX_W-1:0]    scan_next;
    logic                rd_v_reg;
    logic                rd_v_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    rd_idx_next;
    logic                res_valid_reg;
    logic                res_valid_next;

    logic [IDX_W-1:0]    fa_reg;
    logic [IDX_W-1:0]    fa_next;
    logic [IDX_W-1:0]    fb_reg;
    logic [IDX_W-1:0]    fb_next;
    logic                a_oob_reg;
    logic                a_oob_next;
    logic                b_oob_reg;
    logic                b_oob_next;
    rgb_t                col_a_reg;
    rgb_t                col_a_next;
    rgb_t                col_b_reg;
    rgb_t                col_b_next;
    rgb_t                target_reg;
    rgb_t                target_next;
    logic [MUL_XW-1:0]   acc_reg;
    logic [MUL_XW-1:0]   acc_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [DIST_W-1:0]   best_reg;
    logic [DIST_W-1:0]   best_next;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [IDX_W-1:0]    best_idx_next;
    logic [7:0]          out_idx_reg;
    logic [7:0]          out_idx_next;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [DIST_W-1:0]   out_dist_next;

    rgb_t                mem [PALETTE_ENTRIES];
    rgb_t                mem_q_reg;
    logic                wr_en;
    logic [IDX_W-1:0]    rd_addr;

    logic                req_take;
    logic                cfg_write;
    logic [PCT_W-1:0]    pct_sat;
    logic [PCT_W-1:0]    pct_rest;
    logic [MUL_XW-1:0]   mul_x;
    logic [MUL_YW-1:0]   mul_y;
    logic [CHAN_W-1:0]   tgt_chan;

    logic                dist_valid;
    logic [IDX_W-1:0]    dist_idx;
    logic [DIST_W-1:0]   dist_sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_BLEND_PERCENT);
    assign prdata    = (paddr == ADDR_BLEND_PERCENT) ? APB_DATA_W'(blend_reg) : '0;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;

    assign pct_sat  = (blend_reg > PERCENT_FULL) ? PERCENT_FULL : blend_reg;
    assign pct_rest = PERCENT_FULL - pct_sat;
    assign tgt_chan = prod_reg[RECIP_SHIFT +: CHAN_W];

    always_comb
    begin
        if (state_reg == S_MUL_B)
        begin
            mul_x = MUL_XW'(rgb_pick(col_b_reg, ch_reg));
            mul_y = MUL_YW'(pct_rest);
        end
        else if (state_reg == S_DIV)
        begin
            mul_x = acc_reg;
            mul_y = RECIP_100;
        end
        else
        begin
            mul_x = MUL_XW'(rgb_pick(col_a_reg, ch_reg));
            mul_y = MUL_YW'(pct_sat);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        blend_next     = cfg_write ? pwdata[PCT_W-1:0] : blend_reg;
        ch_next        = ch_reg;
        scan_next      = scan_reg;
        rd_v_next      = 1'b0;
        rd_idx_next    = scan_reg;
        res_valid_next = res_valid_reg && res_stall;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        a_oob_next     = a_oob_reg;
        b_oob_next     = b_oob_reg;
        col_a_next     = col_a_reg;
        col_b_next     = col_b_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        prod_next      = PROD_W'(mul_x) * PROD_W'(mul_y);
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        wr_en          = 1'b0;
        rd_addr        = scan_reg;

        if (dist_valid && (dist_sum < best_reg))
        begin
            best_next     = dist_sum;
            best_idx_next = dist_idx;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req_kind_t'(req_type))
                        REQ_WRITE:
                        begin
                            wr_en = ({1'b0, entry_index} < ENTRIES_9);
                        end
                        REQ_BLEND:
                        begin
                            fa_next    = first_index[IDX_W-1:0];
                            fb_next    = second_index[IDX_W-1:0];
                            a_oob_next = ({1'b0, first_index} >= ENTRIES_9);
                            b_oob_next = ({1'b0, second_index} >= ENTRIES_9);
                            state_next = S_RD_A;
                        end
                        REQ_RAW:
                        begin
                            target_next = '{r: red, g: green, b: blue};
                            scan_next   = '0;
                            best_next   = '1;
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_A:
            begin
                rd_addr    = fa_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                rd_addr    = fb_reg;
                col_a_next = a_oob_reg ? rgb_t'('0) : mem_q_reg;
                state_next = S_CAP_B;
            end
            S_CAP_B:
            begin
                col_b_next = b_oob_reg ? rgb_t'('0) : mem_q_reg;
                ch_next    = CH_RED;
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                acc_next   = prod_reg[MUL_XW-1:0];
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next   = acc_reg + prod_reg[MUL_XW-1:0];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_TGT;
            end
            S_TGT:
            begin
                unique case (ch_reg)
                    CH_RED:   target_next.r = tgt_chan;
                    CH_GREEN: target_next.g = tgt_chan;
                    default:  target_next.b = tgt_chan;
                endcase
                if (ch_reg == CH_BLUE)
                begin
                    scan_next  = '0;
                    best_next  = '1;
                    state_next = S_SCAN;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_MUL_A;
                end
            end
            S_SCAN:
            begin
                rd_addr   = scan_reg;
                rd_v_next = 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (dist_valid && (dist_idx == LAST_IDX))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    out_idx_next   = 8'(best_idx_reg);
                    out_dist_next  = best_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            blend_reg     <= '0;
            ch_reg        <= CH_RED;
            scan_reg      <= '0;
            rd_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blend_reg     <= blend_next;
            ch_reg        <= ch_next;
            scan_reg      <= scan_next;
            rd_v_reg      <= rd_v_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        fa_reg       <= fa_next;
        fb_reg       <= fb_next;
        a_oob_reg    <= a_oob_next;
        b_oob_reg    <= b_oob_next;
        col_a_reg    <= col_a_next;
        col_b_reg    <= col_b_next;
        target_reg   <= target_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        out_idx_reg  <= out_idx_next;
        out_dist_reg <= out_dist_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[entry_index[IDX_W-1:0]] <= '{r: red, g: green, b: blue};
        end
        mem_q_reg <= mem[rd_addr];
    end

    pbnc_dist #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (rd_v_reg),
        .entry_idx   (rd_idx_reg),
        .entry       (mem_q_reg),
        .target      (target_reg),
        .dist_valid  (dist_valid),
        .dist_idx    (dist_idx),
        .dist_sum    (dist_sum)
    );

    assign res_valid     = res_valid_reg;
    assign nearest_index = out_idx_reg;
    assign best_distance = out_dist_reg;
    assign exact_match   = (out_dist_reg == '0);

endmodule

[sv/pbnc_checker.sv]
// Port-level assertions for the palette blend block and the bind that attaches them.
`timescale 1ns / 1ps

module pbnc_checker
    import pbnc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic [1:0]        req_type,
    input logic              res_valid,
    input logic              res_stall,
    input logic [DIST_W-1:0] best_distance,
    input logic              exact_match
);

    localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

    // A result transfer that is stalled must still be offered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (exact_match == (best_distance == '0)))
        else $error("exact_match disagrees with best_distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (best_distance <= MAX_DIST))
        else $error("best_distance beyond the largest possible distance");

    // A query occupies the block, so the request channel stalls right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_type == REQ_BLEND || req_type == REQ_RAW)
        |=> req_stall)
        else $error("request accepted during a running search");

    // A new result only appears at the end of a search, while requests are held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
        else $error("result produced without a search in progress");

endmodule

bind palette_blend_nearest_color pbnc_checker u_pbnc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .best_distance (best_distance),
    .exact_match   (exact_match)
);

[tb/nearest_color_checker.sv]
// Checker that follows every transfer of the palette blend and nearest-colour block and compares its results.
`timescale 1ns / 1ps

module nearest_color_checker
    import pbnc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,

    input  logic                  req_valid,
    input  logic                  req_stall,
    input  logic [1:0]            req_type,
    input  logic [7:0]            entry_index,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            first_index,
    input  logic [7:0]            second_index,

    input  logic                  res_valid,
    input  logic                  res_stall,
    input  logic [7:0]            nearest_index,
    input  logic [DIST_W-1:0]     best_distance,
    input  logic                  exact_match,

    output int                    failures,
    output int                    outstanding
);

    typedef struct packed {
        logic [7:0]        index;
        logic [DIST_W-1:0] distance;
        logic              exact;
    } match_t;

    rgb_t             palette [PALETTE_ENTRIES];
    logic [PCT_W-1:0] percent_reg;
    match_t           expected_matches [$];
    int               fail_tally;

    function automatic rgb_t entry_or_black(logic [7:0] idx);
        rgb_t c;
        c = '0;
        if (idx < PALETTE_ENTRIES)
        begin
            c = palette[idx];
        end
        return c;
    endfunction

    function automatic int unsigned square_diff(logic [7:0] a, logic [7:0] b);
        int diff;
        diff = int'(a) - int'(b);
        return diff * diff;
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, int pct);
        int full;
        full = int'(PERCENT_FULL);
        return 8'((int'(a) * pct + int'(b) * (full - pct)) / full);
    endfunction

    function automatic match_t nearest_entry(rgb_t target);
        int unsigned best_dist;
        int unsigned d;
        int          best;
        match_t      m;
        best      = 0;
        best_dist = 32'hFFFF_FFFF;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            d = square_diff(target.r, palette[i].r) + square_diff(target.g, palette[i].g)
                + square_diff(target.b, palette[i].b);
            if (d < best_dist)
            begin
                best      = i;
                best_dist = d;
            end
        end
        m.index    = 8'(best);
        m.distance = DIST_W'(best_dist);
        m.exact    = (best_dist == 0);
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rgb_t   a;
        rgb_t   b;
        rgb_t   target;
        int     pct;
        match_t want;
        if (!rst_n)
        begin
            percent_reg = '0;
            expected_matches.delete();
            fail_tally = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BLEND_PERCENT)
            begin
                percent_reg = pwdata[PCT_W-1:0];
            end

            if (res_valid && !res_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    if (fail_tally < 10)
                    begin
                        $display("%0t: result with nothing expected: index %0d distance %0d",
                                 $realtime, nearest_index, best_distance);
                    end
                    fail_tally++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (nearest_index !== want.index || best_distance !== want.distance
                        || exact_match !== want.exact)
                    begin
                        if (fail_tally < 10)
                        begin
                            $display("%0t: mismatch: index %0d/%0d distance %0d/%0d exact %0b/%0b",
                                     $realtime, want.index, nearest_index, want.distance,
                                     best_distance, want.exact, exact_match);
                        end
                        fail_tally++;
                    end
                end
            end

            if (req_valid && !req_stall)
            begin
                case (req_kind_t'(req_type))
                    REQ_WRITE:
                    begin
                        if (entry_index < PALETTE_ENTRIES)
                        begin
                            palette[entry_index] = {red, green, blue};
                        end
                    end
                    REQ_BLEND:
                    begin
                        a        = entry_or_black(first_index);
                        b        = entry_or_black(second_index);
                        pct      = (percent_reg > PERCENT_FULL) ? int'(PERCENT_FULL)
                                                                : int'(percent_reg);
                        target.r = mix_channel(a.r, b.r, pct);
                        target.g = mix_channel(a.g, b.g, pct);
                        target.b = mix_channel(a.b, b.b, pct);
                        expected_matches.push_back(nearest_entry(target));
                    end
                    REQ_RAW:
                    begin
                        expected_matches.push_back(nearest_entry({red, green, blue}));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        failures    <= fail_tally;
        outstanding <= expected_matches.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the testbench: clock, reset, stimulus and verdict for the palette blend and nearest-colour block.
`timescale 1ns / 1ps

module tb_top;

    import pbnc_pkg::*;

    localparam int ENTRIES      = PALETTE_ENTRIES_DEF;
    localparam int QUIET_CYCLES = ENTRIES + 40;
    localparam int PHASE_ITEMS  = 580;
    localparam int CYCLE_LIMIT  = 6_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            req_type;
    logic [7:0]            entry_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            first_index;
    logic [7:0]            second_index;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [7:0]            nearest_index;
    logic [DIST_W-1:0]     best_distance;
    logic                  exact_match;

    int   check_failures;
    int   pending_results;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   cycle_count        = 0;
    rgb_t colour_shadow [ENTRIES];

    palette_blend_nearest_color #(
        .PALETTE_ENTRIES(ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .entry_index(entry_index),
        .red(red),
        .green(green),
        .blue(blue),
        .first_index(first_index),
        .second_index(second_index),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .nearest_index(nearest_index),
        .best_distance(best_distance),
        .exact_match(exact_match)
    );

    nearest_color_checker #(
        .PALETTE_ENTRIES(ENTRIES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .entry_index(entry_index),
        .red(red),
        .green(green),
        .blue(blue),
        .first_index(first_index),
        .second_index(second_index),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .nearest_index(nearest_index),
        .best_distance(best_distance),
        .exact_match(exact_match),
        .failures(check_failures),
        .outstanding(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] random_channel();
        int v;
        if ($urandom_range(1))
        begin
            v = $urandom_range(255);
        end
        else
        begin
            v = $urandom_range(4) * 64;
            if (v > 255)
            begin
                v = 255;
            end
        end
        return 8'(v);
    endfunction

    function automatic rgb_t random_colour();
        rgb_t c;
        c.r = random_channel();
        c.g = random_channel();
        c.b = random_channel();
        return c;
    endfunction

    task automatic set_blend_percent(input logic [PCT_W-1:0] pct);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BLEND_PERCENT;
        pwdata  = $urandom();
        pwdata[PCT_W-1:0] = pct;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_request(input req_kind_t kind, input logic [7:0] idx, input rgb_t colour,
                                input logic [7:0] fst, input logic [7:0] snd);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid    = 1'b1;
        req_type     = kind;
        entry_index  = idx;
        red          = colour.r;
        green        = colour.g;
        blue         = colour.b;
        first_index  = fst;
        second_index = snd;
        if (kind == REQ_WRITE)
        begin
            colour_shadow[idx] = colour;
        end
        do @(posedge clk); while (req_stall);
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic random_item();
        int   sel;
        rgb_t c;
        sel = $urandom_range(99);
        c   = random_colour();
        if (sel < 35)
        begin
            send_request(REQ_WRITE, 8'($urandom_range(255)), c, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        end
        else if (sel < 65)
        begin
            send_request(REQ_BLEND, 8'($urandom_range(255)), c, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        end
        else if (sel < 95)
        begin
            if ($urandom_range(9) < 4)
            begin
                c = colour_shadow[8'($urandom_range(ENTRIES - 1))];
            end
            send_request(REQ_RAW, 8'($urandom_range(255)), c, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        end
        else
        begin
            send_request(REQ_UNUSED, 8'($urandom_range(255)), c, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        rgb_t c;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = ADDR_BLEND_PERCENT;
        pwdata       = '0;
        req_valid    = 1'b0;
        req_type     = REQ_WRITE;
        entry_index  = '0;
        red          = '0;
        green        = '0;
        blue         = '0;
        first_index  = '0;
        second_index = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_blend_percent(PERCENT_FULL);

        // The whole palette is loaded before any query, with black, white and a duplicate.
        for (int i = 0; i < ENTRIES; i++)
        begin
            c = random_colour();
            if (i == 0)
            begin
                c = '0;
            end
            else if (i == ENTRIES - 1)
            begin
                c = '1;
            end
            else if (i == ENTRIES / 2)
            begin
                c = colour_shadow[3];
            end
            send_request(REQ_WRITE, 8'(i), c, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end

        send_request(REQ_RAW, 8'hFF, 24'h000000, 8'h00, 8'hFF);
        send_request(REQ_RAW, 8'h00, 24'hFFFFFF, 8'hFF, 8'h00);
        send_request(REQ_RAW, 8'h5A, colour_shadow[ENTRIES / 2], 8'hA5, 8'h5A);
        send_request(REQ_RAW, 8'hA5, random_colour(), 8'h5A, 8'hA5);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'h00, 8'hFF);
        send_request(REQ_BLEND, 8'hFF, random_colour(), 8'hFF, 8'h00);
        send_request(REQ_BLEND, 8'h33, random_colour(), 8'h09, 8'h09);
        send_request(REQ_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF);
        c = random_colour();
        send_request(REQ_WRITE, 8'd10, c, 8'h00, 8'h00);
        send_request(REQ_WRITE, 8'd200, c, 8'h00, 8'h00);
        send_request(REQ_RAW, 8'h00, c, 8'h00, 8'h00);

        settle();
        set_blend_percent('0);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'h00, 8'hFF);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'd17, 8'd99);
        settle();
        set_blend_percent('1);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'h00, 8'hFF);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        settle();
        set_blend_percent(7'd50);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'h00, 8'hFF);
        send_request(REQ_BLEND, 8'h00, random_colour(), 8'($urandom_range(255)),
                     8'($urandom_range(255)));

        for (int phase = 0; phase < 3; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    sender_idle_pct    = 12;
                    receiver_stall_pct = 88;
                    set_blend_percent(PCT_W'($urandom_range(1, 99)));
                end
                1:
                begin
                    sender_idle_pct    = 88;
                    receiver_stall_pct = 12;
                    set_blend_percent(PERCENT_FULL);
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    set_blend_percent(PCT_W'($urandom_range(0, 127)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                begin
                    settle();
                end
                random_item();
            end
        end

        settle();
        if (check_failures == 0 && pending_results == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[palette_blend_nearest_color.f]
sv/pbnc_pkg.sv
sv/pbnc_dist.sv
sv/palette_blend_nearest_color.sv
sv/pbnc_checker.sv
tb/nearest_color_checker.sv
tb/tb_top.sv
